/* hw/rtl/b64e_pkg.sv */
// Shared types, constants and the character mapping for the Base64 encoder.
package b64e_pkg;

  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [1:0] PAD_NONE = 2'd0;
  localparam logic [1:0] PAD_ONE  = 2'd1;
  localparam logic [1:0] PAD_TWO  = 2'd2;

  localparam logic [1:0] IDX_LAST = 2'd3;

  // One complete input group, ready to be turned into four characters.
  typedef struct packed {
    logic [23:0] chunk;
    logic [1:0]  pad;
    logic        last;
  } group_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

/* hw/rtl/b64e_front.sv */
// Front end: collects input bytes into groups of up to three and issues each group.
module b64e_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        data_byte,
  input  logic              is_last,
  output logic              grp_wr,
  output b64e_pkg::group_t  grp_data,
  input  logic              grp_full
);
  import b64e_pkg::*;

  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  logic        accept;
  logic        store;

  assign full   = grp_full;
  assign accept = push && !grp_full;
  assign store  = !is_last && (held_count < 2'd2);
  assign grp_wr = accept && !store;

  always_comb begin
    grp_data.last = is_last;
    case (held_count)
      2'd0: begin
        grp_data.chunk = {data_byte, 16'h0000};
        grp_data.pad   = PAD_TWO;
      end
      2'd1: begin
        grp_data.chunk = {held_bytes[15:8], data_byte, 8'h00};
        grp_data.pad   = PAD_ONE;
      end
      default: begin
        grp_data.chunk = {held_bytes, data_byte};
        grp_data.pad   = PAD_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes <= 16'h0000;
      held_count <= 2'd0;
    end else if (accept) begin
      if (store) begin
        if (held_count == 2'd0) begin
          held_bytes <= {data_byte, 8'h00};
        end else begin
          held_bytes[7:0] <= data_byte;
        end
        held_count <= held_count + 2'd1;
      end else begin
        held_bytes <= 16'h0000;
        held_count <= 2'd0;
      end
    end
  end

endmodule

/* hw/rtl/b64e_fifo.sv */
// Short group queue between the front end and the character serializer.
module b64e_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  b64e_pkg::group_t  wr_data,
  output logic              full,
  input  logic              rd_en,
  output b64e_pkg::group_t  rd_data,
  output logic              not_empty
);
  import b64e_pkg::*;

  group_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(FIFO_DEPTH - 1);

  assign full      = (count == DEPTH_C);
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_P) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_P) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full && !rd_en))
    else $error("group queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && !not_empty))
    else $error("group queue read while empty");

endmodule

/* hw/rtl/b64e_back.sv */
// Back end: four characters per queued group, one per cycle unless held, into an output register.
module b64e_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              grp_avail,
  input  b64e_pkg::group_t  grp_data,
  output logic              grp_rd,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_char,
  output logic              group_end,
  output logic              message_end
);
  import b64e_pkg::*;

  group_t      grp;
  logic        grp_valid;
  logic [1:0]  idx;
  logic        out_valid;
  logic        adv;
  logic        emit;
  logic        done;
  logic [7:0]  char_next;

  assign empty = !out_valid;
  // The output register can take a new beat when it is empty or being drained.
  assign adv    = !out_valid || pop;
  assign emit   = adv && grp_valid;
  assign done   = emit && (idx == IDX_LAST);
  assign grp_rd = grp_avail && (!grp_valid || done);

  always_comb begin
    case (idx)
      2'd0:    char_next = b64_char(grp.chunk[23:18]);
      2'd1:    char_next = b64_char(grp.chunk[17:12]);
      2'd2:    char_next = (grp.pad > PAD_ONE) ? PAD_CHAR : b64_char(grp.chunk[11:6]);
      default: char_next = (grp.pad > PAD_NONE) ? PAD_CHAR : b64_char(grp.chunk[5:0]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (grp_rd) begin
      grp <= grp_data;
    end
    if (emit) begin
      out_char    <= char_next;
      group_end   <= (idx == IDX_LAST);
      message_end <= (idx == IDX_LAST) && grp.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (grp_rd) begin
        grp_valid <= 1'b1;
        idx       <= 2'd0;
      end else begin
        if (done) begin
          grp_valid <= 1'b0;
        end
        if (emit) begin
          idx <= idx + 2'd1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (adv) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_msg_end_on_group_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_end) |-> group_end)
    else $error("message end flagged off a group boundary");

  a_group_end_index: assert property (@(posedge clk) disable iff (rst)
    emit |=> (group_end == $past(idx == IDX_LAST)))
    else $error("group end does not match the character index");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (grp_rd && grp_valid) |-> done)
    else $error("new group loaded over one still being emitted");

endmodule

/* hw/rtl/base64_encoder.sv */
// Top level of the streaming Base64 encoder.
//
// Input channel: one raw byte per beat on data_byte, with is_last set on the
// final byte of a message. A beat is taken when push is high and full is low.
// Output channel: one ASCII character per beat on out_char. While empty is
// low the oldest character waits on the ports; it is taken when pop is high.
// group_end marks the fourth character of each group and message_end the
// fourth character of the group closed by is_last. Short final groups are
// padded with '='.
// The front end holds up to two bytes; a third byte or a last byte sends the
// group into a two-entry queue. The serializer emits one character per cycle
// while the output register is drained, so a group occupies it for four
// characters and the single character output port sets the sustained input
// rate. A closing byte passes the queue, the group and output registers.
// When pop stays low the output register holds its beat, the serializer and
// then the queue fill, and full rises; bytes that only fill the front end are
// then held off as well. Reset clears the held bytes, the queue and the
// output register; no characters are pending after reset.
module base64_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       group_end,
  output logic       message_end
);
  import b64e_pkg::*;

  logic   grp_wr;
  group_t grp_wdata;
  logic   grp_full;
  logic   grp_rd;
  group_t grp_rdata;
  logic   grp_avail;

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .is_last   (is_last),
    .grp_wr    (grp_wr),
    .grp_data  (grp_wdata),
    .grp_full  (grp_full)
  );

  b64e_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (grp_wr),
    .wr_data   (grp_wdata),
    .full      (grp_full),
    .rd_en     (grp_rd),
    .rd_data   (grp_rdata),
    .not_empty (grp_avail)
  );

  b64e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .grp_avail   (grp_avail),
    .grp_data    (grp_rdata),
    .grp_rd      (grp_rd),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .group_end   (group_end),
    .message_end (message_end)
  );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the streaming Base64 encoder, with a predictor and random stalls.
module tb_top;
  import b64e_pkg::PAD_CHAR;

  typedef struct packed {
    logic [7:0] ch;
    logic       gend;
    logic       mend;
  } char_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte = 8'h00;
  logic       is_last = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_char;
  logic       group_end;
  logic       message_end;

  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Predictor state: pending bytes and how many of them are held.
  logic [15:0] held_pair = 16'h0000;
  logic [1:0]  held_num = 2'd0;

  char_beat_t pending_chars[$];
  char_beat_t want;

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  base64_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .is_last     (is_last),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .group_end   (group_end),
    .message_end (message_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] symbol_of(input logic [5:0] v);
    return alphabet[v];
  endfunction

  function automatic char_beat_t make_beat(input logic [7:0] c, input logic g, input logic m);
    char_beat_t r;
    r.ch   = c;
    r.gend = g;
    r.mend = m;
    return r;
  endfunction

  // Updates the predictor for one accepted byte and queues the characters it releases.
  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [23:0] chunk;
    int          npad;
    if (!last && held_num < 2'd2) begin
      if (held_num == 2'd0) begin
        held_pair = {b, 8'h00};
      end else begin
        held_pair[7:0] = b;
      end
      held_num = held_num + 2'd1;
    end else begin
      case (held_num)
        2'd0: begin
          chunk = {b, 16'h0000};
          npad  = 2;
        end
        2'd1: begin
          chunk = {held_pair[15:8], b, 8'h00};
          npad  = 1;
        end
        default: begin
          chunk = {held_pair, b};
          npad  = 0;
        end
      endcase
      pending_chars.push_back(make_beat(symbol_of(chunk[23:18]), 1'b0, 1'b0));
      pending_chars.push_back(make_beat(symbol_of(chunk[17:12]), 1'b0, 1'b0));
      pending_chars.push_back(make_beat((npad > 1) ? PAD_CHAR : symbol_of(chunk[11:6]),
                                        1'b0, 1'b0));
      pending_chars.push_back(make_beat((npad > 0) ? PAD_CHAR : symbol_of(chunk[5:0]),
                                        1'b1, last));
      held_pair = 16'h0000;
      held_num  = 2'd0;
    end
  endtask

  // Offers one byte, starting at a falling edge, and returns at the falling edge after it is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push      <= 1'b1;
    data_byte <= b;
    is_last   <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    encode_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  // Waits until every predicted character has been taken, then idles with push low.
  task automatic drain;
    push <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic test_directed;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // A full group that is not the end of the message carries no message_end.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    drain();
  endtask

  task automatic test_random_messages(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 2) begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end else begin
        len = ($urandom_range(15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 9);
        send_message(len);
        sent += len;
      end
    end
    drain();
  endtask

  // The receiver stops for a long stretch while bytes keep coming, so full must rise.
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 300;
    send_message(24);
    send_message(5);
    drain();
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Each character beat is checked against the oldest predicted one.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        errors++;
        if (errors < 200) begin
          $display("%0t: unexpected beat, expected none, actual out_char %h", $time, out_char);
        end
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch) begin
          errors++;
          if (errors < 200) begin
            $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
          end
        end
        if (group_end !== want.gend) begin
          errors++;
          if (errors < 200) begin
            $display("%0t: group_end expected %b actual %b", $time, want.gend, group_end);
          end
        end
        if (message_end !== want.mend) begin
          errors++;
          if (errors < 200) begin
            $display("%0t: message_end expected %b actual %b", $time, want.mend, message_end);
          end
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 9;
    recv_idle_pct = 74;
    test_directed();
    test_random_messages(40);
    send_idle_pct = 74;
    recv_idle_pct = 9;
    test_random_messages(40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_messages(40);
    test_backpressure();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* base64_encoder.f */
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_fifo.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_encoder.sv
sim/tb_top.sv
